[src/kmp_pkg.sv]
// Shared types, constants and helpers for the KMP line matcher.
// Used by kmp_engine and kmp_line_matcher; no dependencies.
package kmp_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int SYM_W           = 8;
  localparam int LINE_W          = 32;

  localparam logic [SYM_W-1:0] LOWER_FIRST = 8'h61;
  localparam logic [SYM_W-1:0] LOWER_LAST  = 8'h7A;
  localparam logic [SYM_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    KIND_PAT  = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_EOL  = 2'd2,
    KIND_NEW  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PFAIL,
    ST_PLOAD,
    ST_READ,
    ST_EVAL,
    ST_TFULL,
    ST_TFWAIT
  } state_t;

  // accepted word handed from the top level to the engine
  typedef struct packed {
    logic             go;
    kind_t            kind;
    logic [SYM_W-1:0] sym;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } status_t;

  function automatic logic [SYM_W-1:0] fold(input logic [SYM_W-1:0] ch, input logic ic);
    logic [SYM_W-1:0] res;
    res = ch;
    if (ic && ch >= LOWER_FIRST && ch <= LOWER_LAST) begin
      res = ch - CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

[src/kmp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/kmp_engine.sv]
// KMP sequencer: pattern store, failure table and the shared fallback compare loop.
// Depends on kmp_pkg and kmp_ram.
module kmp_engine #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF,
  localparam int LEN_W = $clog2(MAX_PATTERN + 1),
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ignore_case,
  input  kmp_pkg::cmd_t    cmd,
  output kmp_pkg::status_t status
);

  kmp_pkg::state_t state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic [kmp_pkg::SYM_W-1:0] c_r, c_nxt;
  logic [kmp_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic is_pat_r, is_pat_nxt;
  logic hit;

  logic                      s_we;
  logic [IDX_W-1:0]          s_waddr, s_raddr;
  logic [kmp_pkg::SYM_W-1:0] s_wdata, s_rdata;
  logic                      f_we;
  logic [IDX_W-1:0]          f_waddr, f_raddr;
  logic [LEN_W-1:0]          f_wdata, f_rdata;

  logic [LEN_W-1:0] len_m1, k_m1, k_inc;
  logic             eq;

  assign len_m1 = len_r - LEN_W'(1);
  assign k_m1   = k_r - LEN_W'(1);
  assign eq     = (kmp_pkg::fold(s_rdata, ignore_case) == c_r);
  assign k_inc  = k_r + LEN_W'(eq);

  kmp_ram #(.WIDTH(kmp_pkg::SYM_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  kmp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmp_pkg::ST_IDLE;
      len_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    c_r      <= c_nxt;
    sym_r    <= sym_nxt;
    is_pat_r <= is_pat_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    k_nxt      = k_r;
    c_nxt      = c_r;
    sym_nxt    = sym_r;
    is_pat_nxt = is_pat_r;
    hit        = 1'b0;
    s_we       = 1'b0;
    s_waddr    = len_r[IDX_W-1:0];
    s_wdata    = sym_r;
    s_raddr    = k_r[IDX_W-1:0];
    f_we       = 1'b0;
    f_waddr    = len_r[IDX_W-1:0];
    f_wdata    = k_inc;
    f_raddr    = k_m1[IDX_W-1:0];
    if (state_r == kmp_pkg::ST_PFAIL || state_r == kmp_pkg::ST_TFULL) begin
      f_raddr = len_m1[IDX_W-1:0];
    end

    case (state_r)
      kmp_pkg::ST_IDLE: begin
        if (cmd.go) begin
          case (cmd.kind)
            kmp_pkg::KIND_PAT: begin
              // characters past the store size are dropped
              if (len_r < LEN_W'(MAX_PATTERN)) begin
                sym_nxt    = cmd.sym;
                c_nxt      = kmp_pkg::fold(cmd.sym, ignore_case);
                is_pat_nxt = 1'b1;
                if (len_r == '0) begin
                  s_we    = 1'b1;
                  s_wdata = cmd.sym;
                  f_we    = 1'b1;
                  f_wdata = '0;
                  len_nxt = LEN_W'(1);
                end else begin
                  state_nxt = kmp_pkg::ST_PFAIL;
                end
              end
            end
            kmp_pkg::KIND_TEXT: begin
              if (len_r == '0) begin
                hit = 1'b1;
              end else begin
                c_nxt      = kmp_pkg::fold(cmd.sym, ignore_case);
                is_pat_nxt = 1'b0;
                k_nxt      = (pos_r >= len_r) ? '0 : pos_r;
                state_nxt  = kmp_pkg::ST_READ;
              end
            end
            kmp_pkg::KIND_EOL: begin
              pos_nxt = '0;
            end
            default: begin
              len_nxt = '0;
              pos_nxt = '0;
            end
          endcase
        end
      end
      kmp_pkg::ST_PFAIL: begin
        state_nxt = kmp_pkg::ST_PLOAD;
      end
      kmp_pkg::ST_PLOAD: begin
        k_nxt     = f_rdata;
        state_nxt = kmp_pkg::ST_READ;
      end
      kmp_pkg::ST_READ: begin
        state_nxt = kmp_pkg::ST_EVAL;
      end
      kmp_pkg::ST_EVAL: begin
        if (k_r != '0 && !eq) begin
          // fall back one failure link and compare again
          k_nxt     = f_rdata;
          state_nxt = kmp_pkg::ST_READ;
        end else if (is_pat_r) begin
          s_we      = 1'b1;
          f_we      = 1'b1;
          len_nxt   = len_r + LEN_W'(1);
          state_nxt = kmp_pkg::ST_IDLE;
        end else if (k_inc >= len_r) begin
          hit       = 1'b1;
          state_nxt = kmp_pkg::ST_TFULL;
        end else begin
          pos_nxt   = k_inc;
          state_nxt = kmp_pkg::ST_IDLE;
        end
      end
      kmp_pkg::ST_TFULL: begin
        state_nxt = kmp_pkg::ST_TFWAIT;
      end
      kmp_pkg::ST_TFWAIT: begin
        pos_nxt   = f_rdata;
        state_nxt = kmp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kmp_pkg::ST_IDLE;
      end
    endcase
  end

  assign status.busy = (state_r != kmp_pkg::ST_IDLE);
  assign status.hit  = hit;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond store size");

  a_pos_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) ? (pos_r == '0) : (pos_r < len_r))
    else $error("match position not below pattern length");

  a_k_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kmp_pkg::ST_READ) |-> (k_r < len_r))
    else $error("compare index outside written pattern");

  a_go_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.go |-> (state_r == kmp_pkg::ST_IDLE))
    else $error("word accepted while sequencer busy");

endmodule

[src/kmp_line_matcher.sv]
// Top level of the streaming KMP line matcher: handshake, line bookkeeping, result register.
// Depends on kmp_pkg and kmp_engine.
//
// Pattern characters (kind 0) build the pattern and its failure table one
// word at a time; text characters (kind 1) advance the match; an end of line
// (kind 2) emits one result word with the saturating line number and hit flag;
// a new search (kind 3) clears the pattern and line count. The sequencer's
// compare loop reads the pattern RAM and failure RAM once per step, each step
// passing a read and an evaluate state: a text word runs one step plus one per
// failure fallback, then TFULL and TFWAIT on a complete match; a pattern word
// first passes PFAIL and PLOAD. Empty-pattern text words, the first pattern
// word, dropped overflow words, end of line and new search are taken in idle.
// Every word is held off while the sequencer is busy; an end of line is also
// held off while a previous result is still stalled at the output.
module kmp_line_matcher #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_kind,
  input  logic [kmp_pkg::SYM_W-1:0]  in_symbol,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kmp_pkg::LINE_W-1:0] out_line_number,
  output logic                       out_matched,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data
);

  kmp_pkg::cmd_t    cmd;
  kmp_pkg::status_t status;
  kmp_pkg::kind_t   kind;

  logic                       ignore_case_r;
  logic                       hit_r, hit_nxt;
  logic [kmp_pkg::LINE_W-1:0] line_r, line_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [kmp_pkg::LINE_W-1:0] out_line_r, out_line_nxt;
  logic                       out_matched_r, out_matched_nxt;
  logic                       accept, eol_go;

  assign kind     = kmp_pkg::kind_t'(in_kind);
  assign in_stall = status.busy ||
                    (out_valid_r && out_stall && kind == kmp_pkg::KIND_EOL);
  assign accept   = in_valid && !in_stall;
  assign eol_go   = accept && kind == kmp_pkg::KIND_EOL;

  assign cmd.go   = accept;
  assign cmd.kind = kind;
  assign cmd.sym  = in_symbol;

  kmp_engine #(.MAX_PATTERN(MAX_PATTERN)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .ignore_case (ignore_case_r),
    .cmd         (cmd),
    .status      (status)
  );

  always_comb begin
    hit_nxt         = hit_r | status.hit;
    line_nxt        = line_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_line_nxt    = out_line_r;
    out_matched_nxt = out_matched_r;
    if (eol_go) begin
      out_valid_nxt   = 1'b1;
      out_line_nxt    = line_r;
      out_matched_nxt = hit_r;
      hit_nxt         = 1'b0;
      if (line_r != '1) begin
        line_nxt = line_r + kmp_pkg::LINE_W'(1);
      end
    end else if (accept && kind == kmp_pkg::KIND_NEW) begin
      hit_nxt  = 1'b0;
      line_nxt = kmp_pkg::LINE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_case_r <= 1'b0;
      hit_r         <= 1'b0;
      line_r        <= kmp_pkg::LINE_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ignore_case_r <= cfg_wr_data;
      end
      hit_r       <= hit_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_line_r    <= out_line_nxt;
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_line_number = out_line_r;
  assign out_matched     = out_matched_r;

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter wrapped to zero");

  a_result_numbered: assert property (@(posedge clk) disable iff (!rst_n)
    eol_go |=> (out_valid_r && out_line_r == $past(line_r)))
    else $error("result word lost its line number");

  a_hit_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    eol_go |=> !hit_r)
    else $error("hit flag survived end of line");

endmodule
